[rtl/smpq_pkg.sv]
`default_nettype none
package smpq_pkg;

  localparam int DEPTH    = 16;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int HANDLE_W = 16;
  localparam int PRIO_W   = 8;
  localparam int OCC_W    = 5;
  localparam int STATUS_W = 2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  typedef logic [HANDLE_W-1:0] handle_t;
  typedef logic [PRIO_W-1:0]   prio_t;

  // broadcast to every cell for one beat
  typedef struct packed {
    logic    insert;
    logic    remove;
    handle_t handle;
    prio_t   prio;
  } cell_ctrl_t;

endpackage
`default_nettype wire

[rtl/stable_min_priority_queue_top.sv]
`default_nettype none
// the result is strobed on done in the cycle after the accepting edge
// throughput: one item per cycle, busy stays low; set by the insert/shift cell row
// the receiver cannot stall, each result is shown for exactly one cycle
// reset: synchronous rst empties the queue and clears done, slot data is not cleared
// results show the head and occupancy after the item
module stable_min_priority_queue_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              mode,
  input  wire logic [smpq_pkg::HANDLE_W-1:0]     entry_handle,
  input  wire logic [smpq_pkg::PRIO_W-1:0]       entry_priority,
  output logic                                   done,
  output logic [smpq_pkg::STATUS_W-1:0]          status,
  output logic                                   head_valid,
  output logic [smpq_pkg::HANDLE_W-1:0]          head_handle,
  output logic [smpq_pkg::PRIO_W-1:0]            head_priority,
  output logic [smpq_pkg::OCC_W-1:0]             occupancy
);

  localparam int D = smpq_pkg::DEPTH;

  logic [smpq_pkg::CNT_W-1:0]    count;
  logic [smpq_pkg::CNT_W-1:0]    count_next;
  logic [smpq_pkg::STATUS_W-1:0] status_next;
  logic                          accept;
  logic                          full;
  logic                          empty;
  smpq_pkg::cell_ctrl_t          ctrl;

  logic [D-1:0]      occ;
  logic [D-1:0]      gt;
  smpq_pkg::handle_t cell_handle [D];
  smpq_pkg::prio_t   cell_prio   [D];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count == smpq_pkg::CNT_W'(D));
  assign empty  = (count == '0);

  always_comb begin
    ctrl.insert = accept && (mode == smpq_pkg::MODE_INSERT) && !full;
    ctrl.remove = accept && (mode == smpq_pkg::MODE_REMOVE) && !empty;
    ctrl.handle = entry_handle;
    ctrl.prio   = entry_priority;
    count_next  = count;
    status_next = smpq_pkg::ST_OK;
    if (ctrl.insert) count_next = count + smpq_pkg::CNT_W'(1);
    if (ctrl.remove) count_next = count - smpq_pkg::CNT_W'(1);
    if (mode == smpq_pkg::MODE_INSERT && full)  status_next = smpq_pkg::ST_FULL;
    if (mode == smpq_pkg::MODE_REMOVE && empty) status_next = smpq_pkg::ST_EMPTY;
  end

  for (genvar i = 0; i < D; i++) begin : g_cell
    logic              l_gt;
    smpq_pkg::handle_t l_handle;
    smpq_pkg::prio_t   l_prio;
    smpq_pkg::handle_t r_handle;
    smpq_pkg::prio_t   r_prio;

    assign occ[i] = (count > smpq_pkg::CNT_W'(i));

    if (i == 0) begin : g_first
      assign l_gt     = 1'b0;
      assign l_handle = cell_handle[i];
      assign l_prio   = cell_prio[i];
    end else begin : g_mid
      assign l_gt     = gt[i-1];
      assign l_handle = cell_handle[i-1];
      assign l_prio   = cell_prio[i-1];
    end

    if (i == D - 1) begin : g_last
      assign r_handle = cell_handle[i];
      assign r_prio   = cell_prio[i];
    end else begin : g_inner
      assign r_handle = cell_handle[i+1];
      assign r_prio   = cell_prio[i+1];
    end

    smpq_cell u_cell (
      .clk          (clk),
      .ctrl         (ctrl),
      .occupied     (occ[i]),
      .left_gt      (l_gt),
      .left_handle  (l_handle),
      .left_prio    (l_prio),
      .right_handle (r_handle),
      .right_prio   (r_prio),
      .gt           (gt[i]),
      .handle       (cell_handle[i]),
      .prio         (cell_prio[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) status <= status_next;
  end

  // head comes straight from the first cell
  assign head_valid    = !empty;
  assign head_handle   = empty ? '0 : cell_handle[0];
  assign head_priority = empty ? '0 : cell_prio[0];
  assign occupancy     = smpq_pkg::OCC_W'(count);

endmodule
`default_nettype wire

[rtl/smpq_cell.sv]
`default_nettype none
module smpq_cell (
  input  wire logic                clk,
  input  wire smpq_pkg::cell_ctrl_t ctrl,
  input  wire logic                occupied,
  input  wire logic                left_gt,
  input  wire smpq_pkg::handle_t   left_handle,
  input  wire smpq_pkg::prio_t     left_prio,
  input  wire smpq_pkg::handle_t   right_handle,
  input  wire smpq_pkg::prio_t     right_prio,
  output logic                     gt,
  output smpq_pkg::handle_t        handle,
  output smpq_pkg::prio_t          prio
);

  smpq_pkg::handle_t handle_next;
  smpq_pkg::prio_t   prio_next;

  // occupied and strictly later than the new entry
  assign gt = occupied && (prio > ctrl.prio);

  always_comb begin
    handle_next = handle;
    prio_next   = prio;
    if (ctrl.insert) begin
      if (left_gt) begin
        handle_next = left_handle;
        prio_next   = left_prio;
      end else if (!occupied || gt) begin
        handle_next = ctrl.handle;
        prio_next   = ctrl.prio;
      end
    end else if (ctrl.remove) begin
      handle_next = right_handle;
      prio_next   = right_prio;
    end
  end

  always_ff @(posedge clk) begin
    handle <= handle_next;
    prio   <= prio_next;
  end

endmodule
`default_nettype wire

[rtl/smpq_checker.sv]
`default_nettype none
module smpq_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic                          done,
  input wire logic [smpq_pkg::STATUS_W-1:0] status,
  input wire logic                          head_valid,
  input wire logic [smpq_pkg::HANDLE_W-1:0] head_handle,
  input wire logic [smpq_pkg::PRIO_W-1:0]   head_priority
);

  // each accepted beat gives one result on the next cycle
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("result missing after accepted beat");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |=> !done)
    else $error("result without accepted beat");

  // remove on empty leaves nothing at the head
  a_empty_head: assert property (@(posedge clk) disable iff (rst)
    (done && status == smpq_pkg::ST_EMPTY) |-> !head_valid)
    else $error("empty status with valid head");

  // a full queue always has a head
  a_full_head: assert property (@(posedge clk) disable iff (rst)
    (done && status == smpq_pkg::ST_FULL) |-> head_valid)
    else $error("full status without head");

  a_zero_head: assert property (@(posedge clk) disable iff (rst)
    (done && !head_valid) |-> (head_handle == '0 && head_priority == '0))
    else $error("empty head not zero");

endmodule

bind stable_min_priority_queue_top smpq_checker u_smpq_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .status        (status),
  .head_valid    (head_valid),
  .head_handle   (head_handle),
  .head_priority (head_priority)
);
`default_nettype wire

[bench/tb_stable_min_priority_queue_top.sv]
module tb_stable_min_priority_queue_top;
  timeunit 1ns;
  timeprecision 1ps;

  import smpq_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_PRINTED    = 40;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                head_valid;
    handle_t             handle;
    prio_t               prio;
    logic [OCC_W-1:0]    occupancy;
  } queue_view_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                mode = MODE_INSERT;
  handle_t             entry_handle = '0;
  prio_t               entry_priority = '0;
  logic                busy;
  logic                done;
  logic [STATUS_W-1:0] status;
  logic                head_valid;
  handle_t             head_handle;
  prio_t               head_priority;
  logic [OCC_W-1:0]    occupancy;

  // sorted copy of the queue contents
  handle_t     sorted_handles [DEPTH];
  prio_t       sorted_prios [DEPTH];
  int          sorted_count = 0;
  queue_view_t pending_views [$];

  int stim_level = 0;
  int n_errors = 0;
  int n_results = 0;
  int n_inserts = 0;
  int n_removes = 0;
  int n_full_drops = 0;
  int n_empty_removes = 0;
  int peak_occupancy = 0;
  int quiet_cycles = 0;

  stable_min_priority_queue_top u_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .mode           (mode),
    .entry_handle   (entry_handle),
    .entry_priority (entry_priority),
    .done           (done),
    .status         (status),
    .head_valid     (head_valid),
    .head_handle    (head_handle),
    .head_priority  (head_priority),
    .occupancy      (occupancy)
  );

  always #1 clk = ~clk;

  function automatic queue_view_t apply_item(logic m, handle_t h, prio_t p);
    queue_view_t v;
    int          pos;
    v = '0;
    v.status = ST_OK;
    if (m == MODE_INSERT) begin
      if (sorted_count >= DEPTH) begin
        v.status = ST_FULL;
        n_full_drops++;
      end else begin
        pos = 0;
        // stable placement: behind every entry of equal or lower priority
        while (pos < sorted_count && sorted_prios[pos] <= p) pos++;
        for (int i = sorted_count; i > pos; i--) begin
          sorted_handles[i] = sorted_handles[i-1];
          sorted_prios[i]   = sorted_prios[i-1];
        end
        sorted_handles[pos] = h;
        sorted_prios[pos]   = p;
        sorted_count++;
        n_inserts++;
      end
    end else begin
      if (sorted_count == 0) begin
        v.status = ST_EMPTY;
        n_empty_removes++;
      end else begin
        for (int i = 1; i < sorted_count; i++) begin
          sorted_handles[i-1] = sorted_handles[i];
          sorted_prios[i-1]   = sorted_prios[i];
        end
        sorted_count--;
        n_removes++;
      end
    end
    if (sorted_count > 0) begin
      v.head_valid = 1'b1;
      v.handle     = sorted_handles[0];
      v.prio       = sorted_prios[0];
    end
    v.occupancy = OCC_W'(sorted_count);
    if (sorted_count > peak_occupancy) peak_occupancy = sorted_count;
    return v;
  endfunction

  task automatic report_mismatch(string what, longint got_v, longint want_v);
    n_errors++;
    if (n_errors <= MAX_PRINTED)
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got_v, want_v);
  endtask

  always @(posedge clk) begin : result_check
    queue_view_t got;
    queue_view_t want;
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (done) begin
        got.status     = status;
        got.head_valid = head_valid;
        got.handle     = head_handle;
        got.prio       = head_priority;
        got.occupancy  = occupancy;
        n_results++;
        if (pending_views.size() == 0) begin
          report_mismatch("result with nothing pending, status", got.status, 0);
        end else begin
          want = pending_views.pop_front();
          if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
          if (got.head_valid !== want.head_valid)
            report_mismatch("head_valid", got.head_valid, want.head_valid);
          if (got.handle !== want.handle)
            report_mismatch("head_handle", got.handle, want.handle);
          if (got.prio !== want.prio)
            report_mismatch("head_priority", got.prio, want.prio);
          if (got.occupancy !== want.occupancy)
            report_mismatch("occupancy", got.occupancy, want.occupancy);
        end
      end
      if (start && !busy) pending_views.push_back(apply_item(mode, entry_handle, entry_priority));
      if (done || (start && !busy)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_beat(logic m, handle_t h, prio_t p);
    @(negedge clk);
    start          = 1'b1;
    mode           = m;
    entry_handle   = h;
    entry_priority = p;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (m == MODE_INSERT && stim_level < DEPTH) stim_level++;
    if (m == MODE_REMOVE && stim_level > 0) stim_level--;
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      @(negedge clk);
      start          = 1'b0;
      entry_handle   = handle_t'($urandom_range(0, 16'hffff));
      entry_priority = prio_t'($urandom_range(0, 8'hff));
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic wait_for_results();
    idle_gap(1);
    while (pending_views.size() != 0) @(posedge clk);
  endtask

  function automatic prio_t pick_priority();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return prio_t'($urandom_range(0, 3));
      4:          return 8'h00;
      5:          return 8'hff;
      default:    return prio_t'($urandom_range(0, 8'hff));
    endcase
  endfunction

  task automatic test_remove_on_empty();
    send_beat(MODE_REMOVE, 16'hffff, 8'hff);
    send_beat(MODE_REMOVE, 16'h0000, 8'h00);
  endtask

  task automatic test_extremes();
    send_beat(MODE_INSERT, 16'hffff, 8'hff);
    send_beat(MODE_INSERT, 16'h0000, 8'h00);
    send_beat(MODE_INSERT, 16'h1234, 8'hff);
    repeat (3) send_beat(MODE_REMOVE, 16'h5a5a, 8'ha5);
  endtask

  // ties first so order of arrival matters, then overflow
  task automatic test_fill_and_overflow();
    for (int i = 0; i < DEPTH; i++) begin
      if (i < DEPTH / 2) send_beat(MODE_INSERT, handle_t'(16'h0100 + i), 8'h10);
      else send_beat(MODE_INSERT, handle_t'(16'h0200 + i), pick_priority());
    end
    send_beat(MODE_INSERT, 16'hbeef, 8'h00);
  endtask

  task automatic test_random_traffic(int n, bit with_gaps);
    int   sent;
    int   burst;
    int   ins_pct;
    logic draining;
    logic m;
    sent = 0;
    draining = (stim_level >= DEPTH / 2);
    while (sent < n) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < n; k++) begin
        if (stim_level >= DEPTH && $urandom_range(0, 2) == 0) draining = 1'b1;
        else if (stim_level == 0 && $urandom_range(0, 2) == 0) draining = 1'b0;
        else if ($urandom_range(0, 39) == 0) draining = ~draining;
        ins_pct = draining ? 20 : 80;
        m = ($urandom_range(0, 99) < ins_pct) ? MODE_INSERT : MODE_REMOVE;
        send_beat(m, handle_t'($urandom_range(0, 16'hffff)), pick_priority());
        sent++;
      end
      if (with_gaps && $urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 6));
    end
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst = 1'b0;
    test_remove_on_empty();
    test_extremes();
    test_fill_and_overflow();
    wait_for_results();
    test_random_traffic(1500, 1'b1);
    wait_for_results();
    test_random_traffic(400, 1'b0);
    wait_for_results();
    repeat (4) @(posedge clk);
    $display("covered %0d inserts, %0d removes, %0d inserts on full, %0d removes on empty",
             n_inserts, n_removes, n_full_drops, n_empty_removes);
    $display("%0d results checked, peak occupancy %0d, %0d mismatches",
             n_results, peak_occupancy, n_errors);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[files.f]
rtl/smpq_pkg.sv
rtl/smpq_cell.sv
rtl/stable_min_priority_queue_top.sv
rtl/smpq_checker.sv
bench/tb_stable_min_priority_queue_top.sv
